// ----- src/clr_pkg.sv -----
// Shared types and constants for the clipped line rasterizer.
// No dependencies; every other file in src imports this package.
package clr_pkg;

  localparam int PORT_COORD_W = 16;
  localparam int CHAN_W       = 8;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 16;
  localparam int IN_DATA_W    = 4 * PORT_COORD_W;
  localparam int OUT_DATA_W   = 2 * PORT_COORD_W + 3 * CHAN_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCREEN_WIDTH  = 3'd0,
    REG_SCREEN_HEIGHT = 3'd1,
    REG_COLOR_RED     = 3'd2,
    REG_COLOR_GREEN   = 3'd3,
    REG_COLOR_BLUE    = 3'd4,
    REG_INVERT_COLORS = 3'd5
  } cfg_reg_e;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_STEP = 1'b1
  } opcode_e;

  typedef struct packed {
    logic [PORT_COORD_W-1:0] screen_width;
    logic [PORT_COORD_W-1:0] screen_height;
    logic [CHAN_W-1:0]       color_red;
    logic [CHAN_W-1:0]       color_green;
    logic [CHAN_W-1:0]       color_blue;
    logic                    invert_colors;
  } cfg_t;

  typedef struct packed {
    logic [PORT_COORD_W-1:0] pixel_x;
    logic [PORT_COORD_W-1:0] pixel_y;
    logic [CHAN_W-1:0]       pixel_red;
    logic [CHAN_W-1:0]       pixel_green;
    logic [CHAN_W-1:0]       pixel_blue;
    logic                    visible;
    logic                    last_pixel;
  } pixel_t;

endpackage

// ----- src/clr_cfg_regs.sv -----
// Configuration register file: screen size, drawing color, invert mode.
// Depends on clr_pkg.
module clr_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          wr_en,
  input  logic [clr_pkg::CFG_IDX_W-1:0] wr_index,
  input  logic [clr_pkg::CFG_DATA_W-1:0] wr_data,
  output clr_pkg::cfg_t                 cfg
);
  import clr_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.screen_width  <= 16'd640;
      cfg_r.screen_height <= 16'd480;
      cfg_r.color_red     <= '0;
      cfg_r.color_green   <= '0;
      cfg_r.color_blue    <= '0;
      cfg_r.invert_colors <= 1'b0;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_SCREEN_WIDTH:  cfg_r.screen_width  <= wr_data;
        REG_SCREEN_HEIGHT: cfg_r.screen_height <= wr_data;
        REG_COLOR_RED:     cfg_r.color_red     <= wr_data[CHAN_W-1:0];
        REG_COLOR_GREEN:   cfg_r.color_green   <= wr_data[CHAN_W-1:0];
        REG_COLOR_BLUE:    cfg_r.color_blue    <= wr_data[CHAN_W-1:0];
        REG_INVERT_COLORS: cfg_r.invert_colors <= wr_data[0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- src/clr_line_engine.sv -----
// Line state and per-transaction datapath: endpoint setup on load,
// one pixel plus remainder-accumulator advance on step. Depends on clr_pkg.
module clr_line_engine #(
  parameter int COORD_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_fire,
  input  logic                             opcode,
  input  logic [clr_pkg::PORT_COORD_W-1:0] start_x,
  input  logic [clr_pkg::PORT_COORD_W-1:0] start_y,
  input  logic [clr_pkg::PORT_COORD_W-1:0] end_x,
  input  logic [clr_pkg::PORT_COORD_W-1:0] end_y,
  input  clr_pkg::cfg_t                    cfg,
  output logic                             res_valid,
  output clr_pkg::pixel_t                  res
);
  import clr_pkg::*;

  localparam int C = COORD_BITS;

  logic         line_active_r, line_active_nxt;
  logic         major_is_y_r, major_is_y_nxt;
  logic         minor_dec_r, minor_dec_nxt;
  logic [C-1:0] major_pos_r, major_pos_nxt;
  logic [C-1:0] major_end_r, major_end_nxt;
  logic [C-1:0] minor_pos_r, minor_pos_nxt;
  logic [C-1:0] major_span_r, major_span_nxt;
  logic [C-1:0] minor_span_r, minor_span_nxt;
  logic [C:0]   acc_r, acc_nxt;

  // load setup
  logic [C-1:0] x0, y0, x1, y1, adx, ady;
  logic [C-1:0] ma0, ma1, mi0, mi1, s_ma0, s_ma1, s_mi0, s_mi1;
  logic         load_major_y, swap;

  // step datapath
  logic [C-1:0] px, py;
  logic         last;
  logic [C:0]   sum_inc;
  logic [PORT_COORD_W-1:0] px_w, py_w;

  always_comb begin
    x0 = start_x[C-1:0];
    y0 = start_y[C-1:0];
    x1 = end_x[C-1:0];
    y1 = end_y[C-1:0];
    adx = (x0 >= x1) ? x0 - x1 : x1 - x0;
    ady = (y0 >= y1) ? y0 - y1 : y1 - y0;
    load_major_y = !((adx != '0) && (ady <= adx));
    ma0 = load_major_y ? y0 : x0;
    ma1 = load_major_y ? y1 : x1;
    mi0 = load_major_y ? x0 : y0;
    mi1 = load_major_y ? x1 : y1;
    swap  = ma1 < ma0;
    s_ma0 = swap ? ma1 : ma0;
    s_ma1 = swap ? ma0 : ma1;
    s_mi0 = swap ? mi1 : mi0;
    s_mi1 = swap ? mi0 : mi1;
  end

  always_comb begin
    px   = major_is_y_r ? minor_pos_r : major_pos_r;
    py   = major_is_y_r ? major_pos_r : minor_pos_r;
    last = major_pos_r == major_end_r;
    px_w = PORT_COORD_W'(px);
    py_w = PORT_COORD_W'(py);
    sum_inc = acc_r + {1'b0, minor_span_r};

    res.pixel_x     = px_w;
    res.pixel_y     = py_w;
    res.pixel_red   = cfg.invert_colors ? ~cfg.color_red   : cfg.color_red;
    res.pixel_green = cfg.invert_colors ? ~cfg.color_green : cfg.color_green;
    res.pixel_blue  = cfg.invert_colors ? ~cfg.color_blue  : cfg.color_blue;
    res.visible     = (px_w < cfg.screen_width) && (py_w < cfg.screen_height);
    res.last_pixel  = last;
    res_valid       = in_fire && (opcode == OP_STEP) && line_active_r;
  end

  always_comb begin
    line_active_nxt = line_active_r;
    major_is_y_nxt  = major_is_y_r;
    minor_dec_nxt   = minor_dec_r;
    major_pos_nxt   = major_pos_r;
    major_end_nxt   = major_end_r;
    minor_pos_nxt   = minor_pos_r;
    major_span_nxt  = major_span_r;
    minor_span_nxt  = minor_span_r;
    acc_nxt         = acc_r;
    if (in_fire && (opcode == OP_LOAD)) begin
      line_active_nxt = 1'b1;
      major_is_y_nxt  = load_major_y;
      major_pos_nxt   = s_ma0;
      major_end_nxt   = s_ma1;
      minor_pos_nxt   = s_mi0;
      major_span_nxt  = s_ma1 - s_ma0;
      minor_span_nxt  = (s_mi0 >= s_mi1) ? s_mi0 - s_mi1 : s_mi1 - s_mi0;
      minor_dec_nxt   = s_mi1 < s_mi0;
      acc_nxt         = '0;
    end else if (res_valid) begin
      if (last) begin
        line_active_nxt = 1'b0;
      end else begin
        major_pos_nxt = major_pos_r + 1'b1;
        if (!minor_dec_r) begin
          if (sum_inc >= {1'b0, major_span_r}) begin
            acc_nxt       = sum_inc - {1'b0, major_span_r};
            minor_pos_nxt = minor_pos_r + 1'b1;
          end else begin
            acc_nxt = sum_inc;
          end
        end else begin
          // accumulator stays below the major span, so the add cannot overflow C+1 bits
          if (acc_r >= {1'b0, minor_span_r}) begin
            acc_nxt = acc_r - {1'b0, minor_span_r};
          end else begin
            acc_nxt       = acc_r + {1'b0, major_span_r} - {1'b0, minor_span_r};
            minor_pos_nxt = minor_pos_r - 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_active_r <= 1'b0;
    end else begin
      line_active_r <= line_active_nxt;
    end
    major_is_y_r <= major_is_y_nxt;
    minor_dec_r  <= minor_dec_nxt;
    major_pos_r  <= major_pos_nxt;
    major_end_r  <= major_end_nxt;
    minor_pos_r  <= minor_pos_nxt;
    major_span_r <= major_span_nxt;
    minor_span_r <= minor_span_nxt;
    acc_r        <= acc_nxt;
  end

endmodule

// ----- src/clipped_line_rasterizer.sv -----
// Clipped line rasterizer: a load transaction (tuser 0) latches two endpoints,
// then each step transaction (tuser 1) emits one pixel of the line, one per clock,
// with the minor coordinate tracked by an exact integer remainder accumulator.
// The output register takes a new result each clock while the consumer keeps
// out_tready high, and a load never produces output.
// Steps after the last pixel, or before any load, produce nothing. Pixels at or past
// the screen size are sent with visible (out_tuser) low. Depends on clr_pkg,
// clr_cfg_regs and clr_line_engine.
module clipped_line_rasterizer #(
  parameter int COORD_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // input stream
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [clr_pkg::IN_DATA_W-1:0]   in_tdata,  // start_x, start_y, end_x, end_y
  input  logic                            in_tuser,  // opcode
  // result stream
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [clr_pkg::OUT_DATA_W-1:0]  out_tdata, // x, y, red, green, blue
  output logic                            out_tuser, // visible
  output logic                            out_tlast, // last_pixel
  // configuration writes
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [clr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [clr_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import clr_pkg::*;

  cfg_t   cfg;
  pixel_t res;
  pixel_t out_r;
  logic   res_valid;
  logic   out_valid_r;
  logic   in_fire;

  assign cfg_ready = 1'b1;
  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;

  clr_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  clr_line_engine #(
    .COORD_BITS (COORD_BITS)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .opcode    (in_tuser),
    .start_x   (in_tdata[15:0]),
    .start_y   (in_tdata[31:16]),
    .end_x     (in_tdata[47:32]),
    .end_y     (in_tdata[63:48]),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= res_valid;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
    if (in_fire && res_valid) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_r.pixel_blue, out_r.pixel_green, out_r.pixel_red,
                       out_r.pixel_y, out_r.pixel_x};
  assign out_tuser  = out_r.visible;
  assign out_tlast  = out_r.last_pixel;

endmodule

// ----- src/clr_checker.sv -----
// Port-level checks for clipped_line_rasterizer, attached by bind.
// Depends on clr_pkg for port widths.
module clr_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tvalid,
  input logic                           in_tready,
  input logic                           in_tuser,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [clr_pkg::OUT_DATA_W-1:0] out_tdata
);
  import clr_pkg::*;

  // a held result must not drop or change under backpressure
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result dropped or changed while stalled");

  // a new result only follows an accepted step transaction
  a_out_from_step: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready && (in_tuser == OP_STEP)))
    else $error("result without a step transaction");

  // an empty output register never blocks the input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

endmodule

bind clipped_line_rasterizer clr_checker u_clr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ----- test/tb_clipped_line_rasterizer.sv -----
// Self-checking testbench for clipped_line_rasterizer: directed lines, then random lines
// under several screen and color settings, checked against an in-bench pixel predictor.
// Depends on clr_pkg and the RTL under src.
module tb_clipped_line_rasterizer;
  import clr_pkg::*;

  localparam int CW          = PORT_COORD_W;
  localparam int DRAIN       = 16;
  localparam int PHASE_ITEMS = 100;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic                  in_tuser   = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;
  logic                  out_tlast;
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;

  clipped_line_rasterizer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor copy of the registers
  logic [CW-1:0]     scr_w   = 16'd640;
  logic [CW-1:0]     scr_h   = 16'd480;
  logic [CHAN_W-1:0] col_r   = '0;
  logic [CHAN_W-1:0] col_g   = '0;
  logic [CHAN_W-1:0] col_b   = '0;
  logic              col_inv = 1'b0;

  // predictor copy of the line state
  logic          ln_active  = 1'b0;
  logic          ln_major_y = 1'b0;
  logic          ln_dec     = 1'b0;
  logic [CW-1:0] ln_pos     = '0;
  logic [CW-1:0] ln_end     = '0;
  logic [CW-1:0] ln_minor   = '0;
  logic [CW-1:0] ln_mspan   = '0;
  logic [CW-1:0] ln_nspan   = '0;
  logic [CW:0]   ln_acc     = '0;

  pixel_t pixel_q[$];
  int     errors     = 0;
  int     items_sent = 0;
  int     tx_stretch = 0;
  bit     tx_calm    = 1'b0;

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $time);
  endtask

  task automatic check_field(string name, logic [CW-1:0] got, logic [CW-1:0] want);
    if (got !== want) report_mismatch(name, 32'(got), 32'(want));
  endtask

  function automatic logic [CW-1:0] abs_diff(logic [CW-1:0] a, logic [CW-1:0] b);
    return (a >= b) ? a - b : b - a;
  endfunction

  function automatic logic [CHAN_W-1:0] shade(logic [CHAN_W-1:0] c);
    return col_inv ? 8'd255 - c : c;
  endfunction

  // Updates the line state for one accepted transaction; queues the pixel a step emits.
  function automatic void rasterize_item(opcode_e op, logic [IN_DATA_W-1:0] d);
    logic [CW-1:0] x0, y0, x1, y1, adx, ady, ma0, ma1, mi0, mi1, tmp;
    pixel_t p;
    if (op == OP_LOAD) begin
      x0 = d[CW-1:0];
      y0 = d[2*CW-1:CW];
      x1 = d[3*CW-1:2*CW];
      y1 = d[4*CW-1:3*CW];
      adx = abs_diff(x0, x1);
      ady = abs_diff(y0, y1);
      ln_major_y = !(adx != '0 && ady <= adx);
      if (ln_major_y) begin
        ma0 = y0; ma1 = y1; mi0 = x0; mi1 = x1;
      end else begin
        ma0 = x0; ma1 = x1; mi0 = y0; mi1 = y1;
      end
      if (ma1 < ma0) begin
        tmp = ma0; ma0 = ma1; ma1 = tmp;
        tmp = mi0; mi0 = mi1; mi1 = tmp;
      end
      ln_pos    = ma0;
      ln_end    = ma1;
      ln_minor  = mi0;
      ln_mspan  = ma1 - ma0;
      ln_nspan  = abs_diff(mi0, mi1);
      ln_dec    = mi1 < mi0;
      ln_acc    = '0;
      ln_active = 1'b1;
    end else if (ln_active) begin
      p.pixel_x     = ln_major_y ? ln_minor : ln_pos;
      p.pixel_y     = ln_major_y ? ln_pos : ln_minor;
      p.pixel_red   = shade(col_r);
      p.pixel_green = shade(col_g);
      p.pixel_blue  = shade(col_b);
      p.visible     = (p.pixel_x < scr_w) && (p.pixel_y < scr_h);
      p.last_pixel  = ln_pos == ln_end;
      pixel_q.push_back(p);
      if (p.last_pixel) begin
        ln_active = 1'b0;
      end else begin
        ln_pos = ln_pos + 1'b1;
        if (!ln_dec) begin
          ln_acc = ln_acc + {1'b0, ln_nspan};
          if (ln_acc >= {1'b0, ln_mspan}) begin
            ln_acc   = ln_acc - {1'b0, ln_mspan};
            ln_minor = ln_minor + 1'b1;
          end
        end else if (ln_acc >= {1'b0, ln_nspan}) begin
          ln_acc = ln_acc - {1'b0, ln_nspan};
        end else begin
          ln_acc   = ln_acc + {1'b0, ln_mspan} - {1'b0, ln_nspan};
          ln_minor = ln_minor - 1'b1;
        end
      end
    end
  endfunction

  // mostly short idle stretches, a few long ones
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 10);
    return $urandom_range(20, 50);
  endfunction

  // tvalid stays high between back-to-back transactions; it drops only in a gap
  task automatic send_item(opcode_e op, logic [IN_DATA_W-1:0] d);
    int gap;
    if (tx_stretch == 0) begin
      tx_stretch = $urandom_range(20, 120);
      tx_calm    = ($urandom_range(0, 3) == 0);
    end
    tx_stretch--;
    gap = (tx_calm || $urandom_range(0, 99) < 55) ? 0 : idle_len();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    in_tuser  <= op;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    rasterize_item(op, d);
    items_sent++;
  endtask

  function automatic logic [IN_DATA_W-1:0] pack_line(logic [CW-1:0] x0, logic [CW-1:0] y0,
                                                      logic [CW-1:0] x1, logic [CW-1:0] y1);
    return {y1, x1, y0, x0};
  endfunction

  task automatic run_line(logic [CW-1:0] x0, logic [CW-1:0] y0, logic [CW-1:0] x1,
                          logic [CW-1:0] y1, int steps);
    send_item(OP_LOAD, pack_line(x0, y0, x1, y1));
    repeat (steps) send_item(OP_STEP, {$urandom, $urandom});
  endtask

  // hold off the sender until every pixel is back and any load has settled
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pixel_q.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic write_settings(logic [CW-1:0] w, logic [CW-1:0] h, logic [CHAN_W-1:0] r,
                                logic [CHAN_W-1:0] g, logic [CHAN_W-1:0] b, logic inv);
    cfg_reg_e        idx[6];
    logic [CW-1:0]   val[6];
    idx = '{REG_SCREEN_WIDTH, REG_SCREEN_HEIGHT, REG_COLOR_RED, REG_COLOR_GREEN,
            REG_COLOR_BLUE, REG_INVERT_COLORS};
    val = '{w, h, {8'd0, r}, {8'd0, g}, {8'd0, b}, {15'd0, inv}};
    for (int i = 0; i < 6; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
    scr_w   = w;
    scr_h   = h;
    col_r   = r;
    col_g   = g;
    col_b   = b;
    col_inv = inv;
  endtask

  task automatic test_idle_and_basic();
    send_item(OP_STEP, {$urandom, $urandom});   // no line loaded yet
    run_line(16'd0, 16'd0, 16'd3, 16'd1, 5);    // last step falls after the final pixel
  endtask

  task automatic test_special_lines();
    run_line(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 2);  // zero length
    run_line(16'd10, 16'd5, 16'd10, 16'd2, 4);            // vertical
    run_line(16'd20, 16'd0, 16'd17, 16'd6, 2);            // steep, minor decreasing, cut short
    run_line(16'd0, 16'd7, 16'd4, 16'd3, 5);              // replaces the line above
  endtask

  task automatic test_clip_extremes();
    wait_idle();
    write_settings(16'd0, 16'hFFFF, 8'd255, 8'd0, 8'd128, 1'b1);
    run_line(16'd1, 16'd0, 16'd0, 16'd1, 2);
  endtask

  function automatic logic [CW-1:0] rand_coord();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return CW'($urandom_range(0, 16'hFFFF));
    if (r < 70) return CW'($urandom_range(0, 300));
    if (r < 85) return CW'($urandom_range(0, 15));
    return CW'($urandom_range(16'hFFF0, 16'hFFFF));
  endfunction

  task automatic random_line();
    logic [CW-1:0] x0, y0, x1, y1;
    int maxd, r, steps;
    r    = $urandom_range(0, 99);
    maxd = (r < 70) ? 12 : (r < 95) ? 60 : 300;
    x0   = rand_coord();
    y0   = rand_coord();
    x1   = $urandom_range(0, 1) ? x0 + CW'($urandom_range(0, maxd))
                                : x0 - CW'($urandom_range(0, maxd));
    y1   = $urandom_range(0, 1) ? y0 + CW'($urandom_range(0, maxd))
                                : y0 - CW'($urandom_range(0, maxd));
    r    = $urandom_range(0, 99);
    if (r < 6) begin
      x1 = x0; y1 = y0;
    end else if (r < 14) begin
      x1 = x0;
    end else if (r < 22) begin
      y1 = y0;
    end else if (r < 30) begin
      y1 = (y1 >= y0) ? y0 + abs_diff(x0, x1) : y0 - abs_diff(x0, x1);
    end
    send_item(OP_LOAD, pack_line(x0, y0, x1, y1));
    steps = int'(ln_mspan) + 1;
    if (steps > 400) steps = 400;
    r = $urandom_range(0, 99);
    if (r < 15) steps += $urandom_range(1, 3);
    else if (r < 25) steps = $urandom_range(0, steps - 1);
    repeat (steps) send_item(OP_STEP, {$urandom, $urandom});
  endtask

  task automatic test_random_lines();
    int target;
    for (int ph = 0; ph < 6; ph++) begin
      wait_idle();
      case (ph)
        0: write_settings(16'hFFFF, 16'hFFFF, 8'd255, 8'd255, 8'd255, 1'b1);
        1: write_settings(16'd1, 16'd1, 8'd0, 8'd0, 8'd0, 1'b0);
        2: write_settings(CW'($urandom_range(1, 16'hFFFF)), CW'($urandom_range(1, 16'hFFFF)),
                          CHAN_W'($urandom), CHAN_W'($urandom), CHAN_W'($urandom),
                          1'($urandom_range(0, 1)));
        3: write_settings(16'd32768, 16'd200, CHAN_W'($urandom), CHAN_W'($urandom),
                          CHAN_W'($urandom), 1'b0);
        4: write_settings(16'd0, 16'd0, CHAN_W'($urandom), CHAN_W'($urandom),
                          CHAN_W'($urandom), 1'b0);
        default: write_settings(CW'($urandom_range(1, 300)), CW'($urandom_range(1, 300)),
                                CHAN_W'($urandom), CHAN_W'($urandom), CHAN_W'($urandom),
                                1'b1);
      endcase
      target = items_sent + PHASE_ITEMS;
      while (items_sent < target) begin
        random_line();
        if ($urandom_range(0, 19) == 0) wait_idle();
      end
    end
  endtask

  // result side back-pressure
  int rx_stall   = 0;
  int rx_stretch = 0;
  bit rx_calm    = 1'b0;
  always @(posedge clk) begin
    if (rx_stretch == 0) begin
      rx_stretch = $urandom_range(50, 300);
      rx_calm    = ($urandom_range(0, 3) == 0);
    end
    rx_stretch--;
    if (rx_stall > 0) begin
      rx_stall--;
      out_tready <= 1'b0;
    end else if (!rx_calm && $urandom_range(0, 99) < 30) begin
      rx_stall = idle_len() - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    pixel_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pixel_q.size() == 0) begin
        report_mismatch("pixel with none expected", out_tdata[31:0], 32'd0);
      end else begin
        want = pixel_q.pop_front();
        check_field("pixel_x", out_tdata[CW-1:0], want.pixel_x);
        check_field("pixel_y", out_tdata[2*CW-1:CW], want.pixel_y);
        check_field("pixel_red", CW'(out_tdata[2*CW+7:2*CW]), CW'(want.pixel_red));
        check_field("pixel_green", CW'(out_tdata[2*CW+15:2*CW+8]), CW'(want.pixel_green));
        check_field("pixel_blue", CW'(out_tdata[2*CW+23:2*CW+16]), CW'(want.pixel_blue));
        check_field("visible", CW'(out_tuser), CW'(want.visible));
        check_field("last_pixel", CW'(out_tlast), CW'(want.last_pixel));
      end
    end
  end

  initial begin
    #2000000;
    $display("[clipped_line_rasterizer] ERROR");
    $finish;
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_idle_and_basic();
    test_special_lines();
    test_clip_extremes();
    test_random_lines();
    wait_idle();
    repeat (DRAIN) @(posedge clk);
    if (pixel_q.size() != 0) report_mismatch("pixels never arrived", 32'd0, 32'(pixel_q.size()));
    if (errors == 0) begin
      $display("[clipped_line_rasterizer] OK");
    end else begin
      $display("[clipped_line_rasterizer] ERROR");
    end
    $finish;
  end

endmodule
